@@ sv/space_vector_pwm_duty_top_macros.svh @@
// ----------------------------------------------------------------------------
// Space vector PWM duty: assertion macros
// Shared assertion wrappers for the RTL modules of the block.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_DUTY_TOP_MACROS_SVH
`define SPACE_VECTOR_PWM_DUTY_TOP_MACROS_SVH

// checked outside reset, clocked by clk
`define SVPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SVPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/svpd_pkg.sv @@
// ----------------------------------------------------------------------------
// svpd_pkg
// Types, constants and the sine table of the space vector PWM duty block.
// ----------------------------------------------------------------------------
`default_nettype none

package svpd_pkg;

  localparam int CountWidth  = 16;
  localparam int FifoDepth   = 4;
  localparam int FifoAw      = $clog2(FifoDepth);
  localparam int SumW        = 18;

  localparam logic [15:0] PeriodReset = 16'd3199;
  localparam logic [14:0] VoltLimit   = 15'd28377;
  localparam logic [15:0] SectorSpan  = 16'h2aaa;
  localparam logic [15:0] Bound1      = 16'h2aaa;
  localparam logic [15:0] Bound2      = 16'h5555;
  localparam logic [15:0] Bound3      = 16'h8000;
  localparam logic [15:0] Bound4      = 16'haaaa;
  localparam logic [15:0] Bound5      = 16'hd555;
  localparam logic [31:0] CountMax    = (32'd1 << CountWidth) - 32'd1;

  localparam int RomDepth = 172;
  localparam logic [7:0] RomLast = 8'(RomDepth - 1);

  typedef enum logic [2:0] {
    Sec0 = 3'd0,
    Sec1 = 3'd1,
    Sec2 = 3'd2,
    Sec3 = 3'd3,
    Sec4 = 3'd4,
    Sec5 = 3'd5
  } sector_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic [14:0] volts;
    sector_t     sector;
    logic [14:0] sin_lead;   // sin(60 - a)
    logic [14:0] sin_lag;    // sin(a)
  } svpd_item_t;

  localparam logic [14:0] SinRom [RomDepth] = '{
    15'd0, 15'd201, 15'd401, 15'd602, 15'd803, 15'd1003, 15'd1204,
    15'd1404, 15'd1605, 15'd1805, 15'd2005, 15'd2206, 15'd2406, 15'd2606,
    15'd2806, 15'd3006, 15'd3205, 15'd3405, 15'd3605, 15'd3804, 15'd4003,
    15'd4202, 15'd4401, 15'd4600, 15'd4799, 15'd4997, 15'd5195, 15'd5393,
    15'd5591, 15'd5789, 15'd5986, 15'd6183, 15'd6380, 15'd6577, 15'd6773,
    15'd6970, 15'd7166, 15'd7361, 15'd7557, 15'd7752, 15'd7947, 15'd8141,
    15'd8335, 15'd8529, 15'd8723, 15'd8916, 15'd9109, 15'd9302, 15'd9494,
    15'd9686, 15'd9877, 15'd10068, 15'd10259, 15'd10449, 15'd10639,
    15'd10829, 15'd11018, 15'd11207, 15'd11395, 15'd11583, 15'd11771,
    15'd11958, 15'd12144, 15'd12331, 15'd12516, 15'd12701, 15'd12886,
    15'd13070, 15'd13254, 15'd13437, 15'd13620, 15'd13802, 15'd13984,
    15'd14165, 15'd14346, 15'd14526, 15'd14706, 15'd14885, 15'd15063,
    15'd15241, 15'd15419, 15'd15595, 15'd15772, 15'd15947, 15'd16122,
    15'd16297, 15'd16470, 15'd16643, 15'd16816, 15'd16988, 15'd17159,
    15'd17330, 15'd17500, 15'd17669, 15'd17838, 15'd18006, 15'd18173,
    15'd18340, 15'd18506, 15'd18671, 15'd18835, 15'd18999, 15'd19162,
    15'd19325, 15'd19487, 15'd19647, 15'd19808, 15'd19967, 15'd20126,
    15'd20284, 15'd20441, 15'd20598, 15'd20753, 15'd20908, 15'd21062,
    15'd21216, 15'd21368, 15'd21520, 15'd21671, 15'd21821, 15'd21970,
    15'd22119, 15'd22266, 15'd22413, 15'd22559, 15'd22704, 15'd22848,
    15'd22992, 15'd23134, 15'd23276, 15'd23417, 15'd23557, 15'd23696,
    15'd23834, 15'd23971, 15'd24107, 15'd24243, 15'd24377, 15'd24511,
    15'd24644, 15'd24776, 15'd24906, 15'd25036, 15'd25165, 15'd25293,
    15'd25420, 15'd25547, 15'd25672, 15'd25796, 15'd25919, 15'd26042,
    15'd26163, 15'd26283, 15'd26403, 15'd26521, 15'd26638, 15'd26755,
    15'd26870, 15'd26984, 15'd27098, 15'd27210, 15'd27321, 15'd27431,
    15'd27541, 15'd27649, 15'd27756, 15'd27862, 15'd27967, 15'd28071,
    15'd28174, 15'd28276, 15'd28377
  };

  // sine lookup, offset within the sector in angle counts
  function automatic logic [14:0] sin_at(input logic [15:0] offset);
    logic [7:0] idx;
    idx = offset[13:6];
    if (offset[15:14] != 2'b00 || idx > RomLast) begin
      idx = RomLast;
    end
    return SinRom[idx];
  endfunction

  // clamp to the count range, then keep the 16-bit field
  function automatic logic [15:0] sat_count(input logic [SumW-1:0] s);
    logic [31:0] wide;
    wide = 32'(s);
    if (wide > CountMax) begin
      wide = CountMax;
    end
    return wide[15:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/svpd_if.sv @@
// ----------------------------------------------------------------------------
// svpd channel interfaces
// Valid/ready channels for voltage/angle requests and compare count results.
// ----------------------------------------------------------------------------
`default_nettype none

interface svpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] volts;
  logic        [15:0] angle;

  modport source (output valid, output volts, output angle, input ready);
  modport sink   (input valid, input volts, input angle, output ready);
endinterface

interface svpd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] phase_a_count;
  logic [15:0] phase_b_count;
  logic [15:0] phase_c_count;
  logic [2:0]  sector;

  modport source (output valid, output phase_a_count, output phase_b_count,
                  output phase_c_count, output sector, input ready);
  modport sink   (input valid, input phase_a_count, input phase_b_count,
                  input phase_c_count, input sector, output ready);
endinterface

`default_nettype wire

@@ sv/space_vector_pwm_duty_top.sv @@
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_top
// Three-phase space vector PWM compare counts from voltage and angle.
//
//   channel   direction  handshake        payload
//   in_ch     sink       valid/ready      volts, angle
//   out_ch    source     valid/ready      phase_a/b/c_count, sector
//   cfg       write      cfg_we           cfg_wdata -> pwm_period
//
// One transaction per cycle sustained while out_ch is ready; after acceptance a
// result passes the front register, queue, three back stages and output register.
// The back end's two multiply stages set the depth of the pipe.
// Reset (rst_n low, synchronous) empties pipe and queue; pwm_period -> 3199.
// A stalled out_ch fills the back stages and the 4-deep queue before in_ch
// drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module space_vector_pwm_duty_top (
  input  wire          clk,
  input  wire          rst_n,
  svpd_in_if.sink      in_ch,
  svpd_out_if.source   out_ch,
  input  wire          cfg_we,
  input  wire [15:0]   cfg_wdata
);
  import svpd_pkg::*;

  logic [15:0] pwm_period_r, pwm_period_nxt;
  logic        push_valid, push_ready;
  svpd_item_t  push_item;
  logic        pop_valid, pop_ready;
  svpd_item_t  pop_item;

  assign pwm_period_nxt = cfg_we ? cfg_wdata : pwm_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= PeriodReset;
    end else begin
      pwm_period_r <= pwm_period_nxt;
    end
  end

  svpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  svpd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  svpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pwm_period (pwm_period_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

@@ sv/svpd_front.sv @@
// ----------------------------------------------------------------------------
// svpd_front
// Accepts requests, clamps the voltage, finds sector and both sine values.
// ----------------------------------------------------------------------------
`default_nettype none

module svpd_front (
  input  wire                     clk,
  input  wire                     rst_n,
  svpd_in_if.sink                 in_ch,
  output logic                    push_valid,
  input  wire                     push_ready,
  output svpd_pkg::svpd_item_t    push_item
);
  import svpd_pkg::*;

  logic        valid_r, valid_nxt;
  svpd_item_t  item_r, item_nxt;
  logic [14:0] volts_clamp;
  sector_t     sec;
  logic [15:0] start;
  logic [15:0] offset;
  logic        load;

  assign load         = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !valid_r || push_ready;
  assign push_valid   = valid_r;
  assign push_item    = item_r;

  always_comb begin
    if (in_ch.volts[15]) begin
      volts_clamp = '0;
    end else if (in_ch.volts[14:0] > VoltLimit) begin
      volts_clamp = VoltLimit;
    end else begin
      volts_clamp = in_ch.volts[14:0];
    end
  end

  always_comb begin
    if (in_ch.angle >= Bound5) begin
      sec = Sec5; start = Bound5;
    end else if (in_ch.angle >= Bound4) begin
      sec = Sec4; start = Bound4;
    end else if (in_ch.angle >= Bound3) begin
      sec = Sec3; start = Bound3;
    end else if (in_ch.angle >= Bound2) begin
      sec = Sec2; start = Bound2;
    end else if (in_ch.angle >= Bound1) begin
      sec = Sec1; start = Bound1;
    end else begin
      sec = Sec0; start = '0;
    end
    offset = in_ch.angle - start;
    if (offset > SectorSpan) begin
      offset = SectorSpan;
    end
  end

  always_comb begin
    item_nxt          = item_r;
    item_nxt.volts    = volts_clamp;
    item_nxt.sector   = sec;
    item_nxt.sin_lead = sin_at(SectorSpan - offset);
    item_nxt.sin_lag  = sin_at(offset);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/svpd_fifo.sv @@
// ----------------------------------------------------------------------------
// svpd_fifo
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "space_vector_pwm_duty_top_macros.svh"

module svpd_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push_valid,
  output logic                    push_ready,
  input  svpd_pkg::svpd_item_t    push_item,
  output logic                    pop_valid,
  input  wire                     pop_ready,
  output svpd_pkg::svpd_item_t    pop_item
);
  import svpd_pkg::*;

  svpd_item_t          mem_r [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FifoAw-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FifoAw:0]     count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r != FifoAw'(0) + (FifoAw+1)'(FifoDepth)) ? 1'b1 : 1'b0;
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // count is unknown until the first reset edge
  `SVPD_ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= (FifoAw+1)'(FifoDepth), "queue count overflow")
  `SVPD_ASSERT(a_push_fills, (push && !pop) |=> (count_r != '0), "pushed item lost")
  `SVPD_ASSERT(a_last_pop, (pop && !push && count_r == (FifoAw+1)'(1)) |=> !pop_valid, "stale entry after last pop")

endmodule

`default_nettype wire

@@ sv/svpd_back.sv @@
// ----------------------------------------------------------------------------
// svpd_back
// Scales the sine values into active times, splits the zero-vector time
// and assigns the three compare counts; four stages ending in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "space_vector_pwm_duty_top_macros.svh"

module svpd_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire [15:0]              pwm_period,
  input  wire                     pop_valid,
  output logic                    pop_ready,
  input  svpd_pkg::svpd_item_t    pop_item,
  svpd_out_if.source              out_ch
);
  import svpd_pkg::*;

  // stage 1: vt = volts * period >> 15
  logic        v1_r, v1_nxt;
  logic [15:0] vt_r;
  logic [14:0] lead1_r, lag1_r;
  sector_t     sec1_r;
  // stage 2: active times
  logic        v2_r, v2_nxt;
  logic [15:0] t1_r, t2_r;
  sector_t     sec2_r;
  // stage 3: sum and half zero time
  logic        v3_r, v3_nxt;
  logic [16:0] act_r;
  logic [15:0] h_r;
  logic [15:0] t1_3_r, t2_3_r;
  sector_t     sec3_r;
  // stage 4: output register
  logic        v4_r, v4_nxt;
  logic [15:0] cnt_a_r, cnt_b_r, cnt_c_r;
  sector_t     sec4_r;

  logic        rdy1, rdy2, rdy3, rdy4;
  logic [30:0] vt_prod, t1_prod, t2_prod;
  logic [16:0] act_sum;
  logic [16:0] zero_time;
  logic [15:0] h_val;
  logic [SumW-1:0] sum_act, sum_t1, sum_t2, sum_h;
  logic [SumW-1:0] a_sum, b_sum, c_sum;

  assign rdy4      = !v4_r || out_ch.ready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign pop_ready = rdy1;

  assign vt_prod = 31'(pop_item.volts) * 31'(pwm_period);
  assign t1_prod = 31'(lead1_r) * 31'(vt_r);
  assign t2_prod = 31'(lag1_r) * 31'(vt_r);

  always_comb begin
    act_sum   = 17'(t1_r) + 17'(t2_r);
    zero_time = 17'(pwm_period) - act_sum;
    // active time beyond the period leaves no zero vector
    h_val     = (act_sum > 17'(pwm_period)) ? 16'd0 : zero_time[16:1];
  end

  always_comb begin
    sum_h   = SumW'(h_r);
    sum_act = SumW'(act_r) + sum_h;
    sum_t1  = SumW'(t1_3_r) + sum_h;
    sum_t2  = SumW'(t2_3_r) + sum_h;
    case (sec3_r)
      Sec0: begin a_sum = sum_act; b_sum = sum_t2;  c_sum = sum_h;   end
      Sec1: begin a_sum = sum_t1;  b_sum = sum_act; c_sum = sum_h;   end
      Sec2: begin a_sum = sum_h;   b_sum = sum_act; c_sum = sum_t2;  end
      Sec3: begin a_sum = sum_h;   b_sum = sum_t1;  c_sum = sum_act; end
      Sec4: begin a_sum = sum_t2;  b_sum = sum_h;   c_sum = sum_act; end
      default: begin a_sum = sum_act; b_sum = sum_h; c_sum = sum_t1; end
    endcase
  end

  always_comb begin
    v1_nxt = rdy1 ? pop_valid : v1_r;
    v2_nxt = rdy2 ? v1_r      : v2_r;
    v3_nxt = rdy3 ? v2_r      : v3_r;
    v4_nxt = rdy4 ? v3_r      : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && pop_valid) begin
      vt_r    <= vt_prod[30:15];
      lead1_r <= pop_item.sin_lead;
      lag1_r  <= pop_item.sin_lag;
      sec1_r  <= pop_item.sector;
    end
    if (rdy2 && v1_r) begin
      t1_r   <= t1_prod[30:15];
      t2_r   <= t2_prod[30:15];
      sec2_r <= sec1_r;
    end
    if (rdy3 && v2_r) begin
      act_r  <= act_sum;
      h_r    <= h_val;
      t1_3_r <= t1_r;
      t2_3_r <= t2_r;
      sec3_r <= sec2_r;
    end
    if (rdy4 && v3_r) begin
      cnt_a_r <= sat_count(a_sum);
      cnt_b_r <= sat_count(b_sum);
      cnt_c_r <= sat_count(c_sum);
      sec4_r  <= sec3_r;
    end
  end

  assign out_ch.valid         = v4_r;
  assign out_ch.phase_a_count = cnt_a_r;
  assign out_ch.phase_b_count = cnt_b_r;
  assign out_ch.phase_c_count = cnt_c_r;
  assign out_ch.sector        = 3'(sec4_r);

  `SVPD_ASSERT(a_sector_range, out_ch.valid |-> (out_ch.sector <= 3'd5), "sector out of range")
  `SVPD_ASSERT(a_half_zero, v3_r |-> (h_r <= pwm_period[15:1]), "half zero time above half period")
  `SVPD_ASSERT(a_stage3_hold, (v3_r && !rdy4) |=> (v3_r && $stable(act_r)), "stalled stage lost")

endmodule

`default_nettype wire
